### hdl/lpm_pkg.sv
`timescale 1ns / 1ps

package lpm_pkg;

	localparam logic [7:0] SYM_ONE = 8'h5F;  // '_'
	localparam logic [7:0] SYM_ANY = 8'h25;  // '%'

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_TEXT   = 2'd1,
		MODE_END    = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] symbol;
	} item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

	// what one position hands to the next one up the row
	typedef struct packed {
		logic act;    // current column bit
		logic nxt;    // column bit after this text byte
		logic start;  // re-armed column bit
		logic used;   // position holds a pattern symbol
	} link_t;

endpackage

### hdl/lpm_cell.sv
`timescale 1ns / 1ps

module lpm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  lpm_pkg::item_t item,
	input  lpm_pkg::link_t left,
	output lpm_pkg::link_t right
);

	logic [7:0] pat_q;
	logic       used_q;
	logic       act_q;

	logic       write_here;
	logic       eff_used;
	logic [7:0] eff_pat;
	logic       start;
	logic       nxt;

	// first free position takes the appended symbol
	assign write_here = (item.mode == lpm_pkg::MODE_APPEND) && left.used && !used_q;
	assign eff_used   = (item.mode == lpm_pkg::MODE_CLEAR) ? 1'b0 : (used_q | write_here);
	assign eff_pat    = write_here ? item.symbol : pat_q;
	assign start      = left.start && eff_used && (eff_pat == lpm_pkg::SYM_ANY);

	always_comb begin
		if (!used_q) begin
			nxt = 1'b0;
		end else if (pat_q == lpm_pkg::SYM_ANY) begin
			nxt = left.nxt | act_q;
		end else if (pat_q == lpm_pkg::SYM_ONE || pat_q == item.symbol) begin
			nxt = left.act;
		end else begin
			nxt = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && write_here) begin
			pat_q <= item.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else if (take) begin
			if (item.mode == lpm_pkg::MODE_CLEAR) begin
				used_q <= 1'b0;
			end else if (write_here) begin
				used_q <= 1'b1;
			end
			act_q <= (item.mode == lpm_pkg::MODE_TEXT) ? nxt : start;
		end
	end

	assign right.act   = act_q;
	assign right.nxt   = nxt;
	assign right.start = start;
	assign right.used  = used_q;

endmodule

### hdl/like_pattern_match.sv
`timescale 1ns / 1ps

// SQL LIKE matcher: '_' matches one byte, '%' any run of bytes.
// Input channel (item_valid / item_stall / item) carries one transaction per
// cycle when not stalled: append a pattern byte, feed a text byte, end the
// text, or clear the pattern. Only an end-of-text transaction yields a result,
// on the output channel (result_valid / result_stall / result): matched and
// the sticky pattern_overflow flag (set when an append finds all PATTERN_MAX
// positions in use, cleared by a clear transaction).
// Throughput is one transaction per cycle while item_stall is low. Each result
// is registered when its end-of-text transaction is taken. The cycle time is
// set by the carry ripple of the '%' closure through the PATTERN_MAX cells.
// The result side has a two-entry buffer: with one result waiting, input
// transactions are still taken; item_stall rises only while a second result
// is held, and drops once the receiver takes the first.
// Reset empties the pattern, clears the overflow flag and arms the column
// with only position zero set; pattern bytes are not cleared.

module like_pattern_match #(
	parameter int PATTERN_MAX = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  lpm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output lpm_pkg::result_t result
);

	lpm_pkg::link_t links [0:PATTERN_MAX];

	logic take;
	logic act0_q;
	logic overflow_q;
	logic full;
	logic matched;

	logic [PATTERN_MAX+1:0] used_v;
	logic [PATTERN_MAX:0]   act_v;
	logic [PATTERN_MAX:0]   sel;

	lpm_pkg::result_t res;
	lpm_pkg::result_t skid_q;
	logic             skid_valid_q;
	logic             out_valid_q;
	lpm_pkg::result_t out_q;
	logic             out_fire;
	logic             res_valid;

	assign take = item_valid && !item_stall;

	assign links[0].act   = act0_q;
	assign links[0].nxt   = 1'b0;
	assign links[0].start = 1'b1;
	assign links[0].used  = 1'b1;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		lpm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.take   (take),
			.item   (item),
			.left   (links[j]),
			.right  (links[j+1])
		);
	end

	assign full = links[PATTERN_MAX].used;

	// column bit at the pattern length: last used position
	always_comb begin
		used_v[PATTERN_MAX+1] = 1'b0;
		for (int j = 0; j <= PATTERN_MAX; j++) begin
			used_v[j] = links[j].used;
			act_v[j]  = links[j].act;
		end
		for (int j = 0; j <= PATTERN_MAX; j++) begin
			sel[j] = act_v[j] & used_v[j] & ~used_v[j+1];
		end
	end

	assign matched = |sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act0_q     <= 1'b1;
			overflow_q <= 1'b0;
		end else if (take) begin
			act0_q <= (item.mode != lpm_pkg::MODE_TEXT);
			if (item.mode == lpm_pkg::MODE_CLEAR) begin
				overflow_q <= 1'b0;
			end else if (item.mode == lpm_pkg::MODE_APPEND && full) begin
				overflow_q <= 1'b1;
			end
		end
	end

	assign res_valid            = take && (item.mode == lpm_pkg::MODE_END);
	assign res.matched          = matched;
	assign res.pattern_overflow = overflow_q;
	assign out_fire             = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign item_stall   = skid_valid_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### hdl/lpm_checker.sv
`timescale 1ns / 1ps

module lpm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input lpm_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input lpm_pkg::result_t result
);

	logic acc;
	assign acc = item_valid && !item_stall;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_stall_buf: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with no result waiting");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(acc && item.mode == lpm_pkg::MODE_END))
		else $error("result without end-of-text transaction");

	// empty pattern and empty text must match, with no overflow
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item.mode == lpm_pkg::MODE_CLEAR) ##1
		(acc && item.mode == lpm_pkg::MODE_END && !result_valid)
		|=> result_valid && result.matched && !result.pattern_overflow)
		else $error("empty pattern against empty text gave wrong result");

endmodule

bind like_pattern_match lpm_checker u_lpm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

### bench/like_pattern_match_tb.sv
`timescale 1ns / 1ps

module like_pattern_match_tb;

	localparam int PMAX      = 32;
	localparam int N_ITEMS   = 1500;
	localparam int CYC_LIMIT = 400000;
	localparam int HOLD_LEN  = 200;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	lpm_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	lpm_pkg::result_t result;

	like_pattern_match #(.PATTERN_MAX(PMAX)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// matcher state as the block should hold it
	logic [7:0]    pat_mem [PMAX];
	int            pat_len;
	logic [PMAX:0] col_bits;
	logic          ovf_seen;

	lpm_pkg::item_t   item_q [$];
	lpm_pkg::result_t match_q [$];
	logic [7:0]       shadow_pat [$];

	int               total;
	int               sent;
	int               results_seen;
	int               errors;
	int               cycles;
	int               hold_left;
	bit               hold_done;
	bit               busy;
	logic [1:0]       phase = 2'd0;
	lpm_pkg::result_t want;

	// start column: bit 0 plus every position reached through leading '%'
	function automatic logic [PMAX:0] armed_column();
		logic [PMAX:0] col;
		bit            run;
		col    = '0;
		col[0] = 1'b1;
		run    = 1'b1;
		for (int j = 0; j < PMAX; j++) begin
			if (run && j < pat_len && pat_mem[j] == lpm_pkg::SYM_ANY)
				col[j + 1] = 1'b1;
			else
				run = 1'b0;
		end
		return col;
	endfunction

	function automatic logic [PMAX:0] column_after(logic [7:0] c);
		logic [PMAX:0] nxt;
		logic [7:0]    p;
		nxt = '0;
		for (int j = 1; j <= PMAX; j++) begin
			if (j <= pat_len) begin
				p = pat_mem[j - 1];
				if (p == lpm_pkg::SYM_ANY)
					nxt[j] = nxt[j - 1] | col_bits[j];
				else if (p == lpm_pkg::SYM_ONE || p == c)
					nxt[j] = col_bits[j - 1];
			end
		end
		return nxt;
	endfunction

	task automatic track_item(lpm_pkg::item_t it);
		lpm_pkg::result_t r;
		case (it.mode)
			lpm_pkg::MODE_APPEND: begin
				if (pat_len < PMAX) begin
					pat_mem[pat_len] = it.symbol;
					pat_len++;
				end else begin
					ovf_seen = 1'b1;
				end
				col_bits = armed_column();
			end
			lpm_pkg::MODE_TEXT: begin
				col_bits = column_after(it.symbol);
			end
			lpm_pkg::MODE_END: begin
				r.matched          = col_bits[pat_len];
				r.pattern_overflow = ovf_seen;
				match_q.push_back(r);
				col_bits = armed_column();
			end
			default: begin
				pat_len  = 0;
				ovf_seen = 1'b0;
				col_bits = armed_column();
			end
		endcase
	endtask

	// ---- stimulus building ----
	task automatic emit(lpm_pkg::mode_t m, logic [7:0] s);
		lpm_pkg::item_t it;
		it.mode   = m;
		it.symbol = s;
		item_q.push_back(it);
		if (m == lpm_pkg::MODE_APPEND && shadow_pat.size() < PMAX)
			shadow_pat.push_back(s);
		else if (m == lpm_pkg::MODE_CLEAR)
			shadow_pat.delete();
	endtask

	function automatic logic [7:0] pick_pattern_sym();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return lpm_pkg::SYM_ANY;
		else if (r < 4)
			return lpm_pkg::SYM_ONE;
		else if (r < 9)
			return 8'h61 + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_filler();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 8'h61 + 8'($urandom_range(0, 2));
		else if (r == 6)
			return ($urandom_range(0, 1) != 0) ? lpm_pkg::SYM_ANY : lpm_pkg::SYM_ONE;
		return 8'($urandom_range(0, 255));
	endfunction

	// text built to fit the stored pattern; spoil alters it at one spot, which may break the match
	task automatic emit_string(bit spoil);
		int         at;
		int         how;
		logic [7:0] p;
		at = (shadow_pat.size() > 0) ? $urandom_range(0, shadow_pat.size() - 1) : 0;
		if (spoil && shadow_pat.size() == 0)
			emit(lpm_pkg::MODE_TEXT, pick_filler());
		for (int i = 0; i < shadow_pat.size(); i++) begin
			p = shadow_pat[i];
			if (spoil && i == at) begin
				how = $urandom_range(0, 2);
				if (how == 1) begin
					emit(lpm_pkg::MODE_TEXT, pick_filler());
				end else if (how == 2) begin
					emit(lpm_pkg::MODE_TEXT, pick_filler());
					emit(lpm_pkg::MODE_TEXT, pick_filler());
				end
			end else if (p == lpm_pkg::SYM_ANY) begin
				repeat ($urandom_range(0, 3)) emit(lpm_pkg::MODE_TEXT, pick_filler());
			end else if (p == lpm_pkg::SYM_ONE) begin
				emit(lpm_pkg::MODE_TEXT, pick_filler());
			end else begin
				emit(lpm_pkg::MODE_TEXT, p);
			end
		end
		emit(lpm_pkg::MODE_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic build_stimulus();
		int  r;
		int  plen;
		bit  first;
		// empty pattern cases
		emit(lpm_pkg::MODE_END, 8'h00);
		emit(lpm_pkg::MODE_TEXT, 8'h61);
		emit(lpm_pkg::MODE_END, 8'h00);
		emit(lpm_pkg::MODE_CLEAR, 8'hFF);
		// lone '%' matches anything, empty text included
		emit(lpm_pkg::MODE_APPEND, lpm_pkg::SYM_ANY);
		emit(lpm_pkg::MODE_END, 8'hFF);
		emit(lpm_pkg::MODE_TEXT, 8'h00);
		emit(lpm_pkg::MODE_TEXT, 8'hFF);
		emit(lpm_pkg::MODE_END, 8'h00);
		// "a_%b"
		emit(lpm_pkg::MODE_CLEAR, 8'h00);
		emit(lpm_pkg::MODE_APPEND, 8'h61);
		emit(lpm_pkg::MODE_APPEND, lpm_pkg::SYM_ONE);
		emit(lpm_pkg::MODE_APPEND, lpm_pkg::SYM_ANY);
		emit(lpm_pkg::MODE_APPEND, 8'h62);
		emit(lpm_pkg::MODE_TEXT, 8'h61);
		emit(lpm_pkg::MODE_TEXT, 8'hFF);
		emit(lpm_pkg::MODE_TEXT, 8'h62);
		emit(lpm_pkg::MODE_END, 8'h00);
		emit(lpm_pkg::MODE_TEXT, 8'h61);
		emit(lpm_pkg::MODE_TEXT, 8'h62);
		emit(lpm_pkg::MODE_END, 8'h00);
		// append in the middle of a text discards what came before
		emit(lpm_pkg::MODE_TEXT, 8'h61);
		emit(lpm_pkg::MODE_APPEND, 8'h63);
		emit(lpm_pkg::MODE_TEXT, 8'h61);
		emit(lpm_pkg::MODE_TEXT, 8'h78);
		emit(lpm_pkg::MODE_TEXT, 8'h62);
		emit(lpm_pkg::MODE_TEXT, 8'h63);
		emit(lpm_pkg::MODE_END, 8'hFF);

		first = 1'b1;
		while (item_q.size() < N_ITEMS) begin
			r = $urandom_range(0, 19);
			if (r < 2) begin
				repeat ($urandom_range(1, 4))
					emit(lpm_pkg::mode_t'($urandom_range(0, 3)),
					     8'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 9) != 0)
					emit(lpm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)));
				if (first || $urandom_range(0, 11) == 0)
					plen = $urandom_range(28, 40);
				else
					plen = $urandom_range(0, 8);
				first = 1'b0;
				repeat (plen) emit(lpm_pkg::MODE_APPEND, pick_pattern_sym());
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 9) == 0) begin
						repeat ($urandom_range(1, 3))
							emit(lpm_pkg::MODE_TEXT, pick_filler());
						emit(lpm_pkg::MODE_APPEND, pick_pattern_sym());
					end
					emit_string($urandom_range(0, 3) == 0);
				end
			end
		end
	endtask

	function automatic int send_idle_pct();
		case (phase)
			2'd0:    return 32;
			2'd1:    return 84;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (phase)
			2'd0:    return 84;
			2'd1:    return 32;
			default: return 0;
		endcase
	endfunction

	// ---- driver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			phase      <= 2'd0;
		end else begin
			busy = item_valid;
			if (item_valid && !item_stall) begin
				track_item(item);
				sent++;
				busy = 1'b0;
			end
			phase <= (sent < total / 3) ? 2'd0 : (sent < 2 * total / 3) ? 2'd1 : 2'd2;
			if (!busy) begin
				// one pause mid-run until the block has drained every result
				if (item_q.size() > 0 && !(sent == total / 2 && match_q.size() != 0)
				    && $urandom_range(0, 99) >= send_idle_pct()) begin
					item       <= item_q.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor and receiver stall ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (match_q.size() == 0) begin
					$display("%0t: unexpected result matched %0b pattern_overflow %0b",
					         $time, result.matched, result.pattern_overflow);
					errors++;
				end else begin
					want = match_q.pop_front();
					if (result.matched !== want.matched) begin
						$display("%0t: matched expected %0b actual %0b",
						         $time, want.matched, result.matched);
						errors++;
					end
					if (result.pattern_overflow !== want.pattern_overflow) begin
						$display("%0t: pattern_overflow expected %0b actual %0b",
						         $time, want.pattern_overflow, result.pattern_overflow);
						errors++;
					end
				end
			end
			// long hold-off while the sender streams, to back up the input side
			if (!hold_done && phase == 2'd2) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("like_pattern_match_tb failed");
			$finish;
		end
	end

	initial begin
		sent         = 0;
		results_seen = 0;
		errors       = 0;
		cycles       = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		pat_len      = 0;
		ovf_seen     = 1'b0;
		for (int j = 0; j < PMAX; j++)
			pat_mem[j] = 8'h00;
		col_bits = armed_column();
		build_stimulus();
		shadow_pat.delete();
		total = item_q.size();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (sent < total || match_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && match_q.size() == 0)
			$display("like_pattern_match_tb passed");
		else
			$display("like_pattern_match_tb failed");
		$finish;
	end

endmodule
